// ===== rtl/core/atpc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the accelerometer tilt-proof checker.
// Holds field widths, phase codes and configuration register indexes.
// No dependencies.
package atpc_pkg;

	localparam int NUM_AXES   = 3;
	localparam int RAW_W      = 16;
	localparam int ABS_W      = 17;
	localparam int PROD_W     = 2 * ABS_W;
	localparam int SUM_W      = 36;
	localparam int ROOT_W     = 18;
	localparam int THR_W      = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	localparam logic [ABS_W-1:0] MG_PER_G = ABS_W'(1000);
	localparam int LSB_SHIFT = 8;

	localparam logic [1:0] PHASE_RUNNING = 2'd0;
	localparam logic [1:0] PHASE_PASSED  = 2'd1;
	localparam logic [1:0] PHASE_LOST    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AXES_NEED  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ERRORS = 2'd2;

	localparam logic [THR_W-1:0] THRESHOLD_RESET  = THR_W'(700);
	localparam logic [1:0]       AXES_NEED_RESET  = 2'd2;
	localparam logic [2:0]       MAX_ERRORS_RESET = 3'd3;

endpackage

// ===== rtl/core/atpc_if.sv =====
`timescale 1ns / 1ps
// Handshake channels of the tilt-proof checker: poll sample in, result out.
// Depends on atpc_pkg.
interface atpc_sample_if import atpc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    read_ok;
	logic signed [RAW_W-1:0] raw_x;
	logic signed [RAW_W-1:0] raw_y;
	logic signed [RAW_W-1:0] raw_z;

	modport source (output valid, read_ok, raw_x, raw_y, raw_z, input ready);
	modport sink (input valid, read_ok, raw_x, raw_y, raw_z, output ready);
endinterface

interface atpc_result_if import atpc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        phase;
	logic [ROOT_W-1:0] magnitude_mg;
	logic [1:0]        dominant_axis;
	logic              dominant_strong;
	logic [2:0]        axes_seen_mask;
	logic [1:0]        axes_seen_count;

	modport source (output valid, phase, magnitude_mg, dominant_axis, dominant_strong,
		axes_seen_mask, axes_seen_count, input ready);
	modport sink (input valid, phase, magnitude_mg, dominant_axis, dominant_strong,
		axes_seen_mask, axes_seen_count, output ready);
endinterface

// ===== rtl/core/atpc_mul.sv =====
`timescale 1ns / 1ps
// Shared 17 x 17 bit unsigned multiplier with a registered product.
// Depends on atpc_pkg.
module atpc_mul import atpc_pkg::*; (
	input  logic              clk,
	input  logic [ABS_W-1:0]  op_a,
	input  logic [ABS_W-1:0]  op_b,
	output logic [PROD_W-1:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(op_a) * PROD_W'(op_b);
	end

endmodule

// ===== rtl/core/atpc_sqrt.sv =====
`timescale 1ns / 1ps
// Iterative floor square root, one result bit per cycle.
// Depends on atpc_pkg.
module atpc_sqrt import atpc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SUM_W-1:0]  radicand,
	output logic              done_q,
	output logic [ROOT_W-1:0] root
);

	logic              busy_q;
	logic [SUM_W-1:0]  rem_q;
	logic [SUM_W-1:0]  root_q;
	logic [SUM_W-1:0]  bit_q;
	logic [SUM_W:0]    trial;
	logic              fits;

	assign trial = {1'b0, root_q} + {1'b0, bit_q};
	assign fits  = {1'b0, rem_q} >= trial;
	assign root  = root_q[ROOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= radicand;
			root_q <= '0;
			bit_q  <= SUM_W'(1) << (SUM_W - 2);
		end else if (busy_q) begin
			if (fits) begin
				rem_q  <= rem_q - trial[SUM_W-1:0];
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

// ===== rtl/core/accel_tilt_proof_checker_core.sv =====
`timescale 1ns / 1ps
// Top level of the accelerometer tilt-proof checker: sequencer, state and output word.
// Depends on atpc_pkg, atpc_if, atpc_mul and atpc_sqrt.
//
// Channel   Direction  Word
// sample    in         read_ok, raw_x, raw_y, raw_z
// result    out        phase, magnitude_mg, dominant_axis, dominant_strong,
//                      axes_seen_mask, axes_seen_count
// wr_*      in         configuration write: wr_en, wr_index, wr_data
//
// A good read keeps sample.ready low from IDLE through CONV, SQ, SQRT and FINISH, so no
// new word is taken meanwhile. CONV converts the axes, SQ squares them on the shared
// multiplier, the 18-step square root unit runs to its done pulse and FINISH hands off.
// A failed read goes from IDLE to FINISH. The result register lets a new word be taken
// while a result waits; the sequencer stalls only if a new result meets a full register.
// Reset clears the seen mask, the error run and the configuration to their defaults.
module accel_tilt_proof_checker_core import atpc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	atpc_sample_if.sink          sample,
	atpc_result_if.source        result
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_CONV   = 5'b00010,
		S_SQ     = 5'b00100,
		S_SQRT   = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	state_t             state_q;
	logic [1:0]         cnt_q;
	logic [THR_W-1:0]   thr_q;
	logic [1:0]         need_q;
	logic [2:0]         max_err_q;
	logic [2:0]         seen_q;
	logic [2:0]         err_q;
	logic               emit_q;
	logic               lost_q;
	logic               strong_q;
	logic [1:0]         dom_q;
	logic [ABS_W-1:0]   best_q;
	logic [SUM_W-1:0]   sum_q;
	logic signed [RAW_W-1:0] raw_q [NUM_AXES];
	logic [ABS_W-1:0]   absmg_q [NUM_AXES];

	logic               accept;
	logic               out_free;
	logic               emit_fire;
	logic [2:0]         err_next;
	logic [RAW_W-1:0]   raw_sel;
	logic [ABS_W-1:0]   raw_abs;
	logic [ABS_W-1:0]   op_a;
	logic [ABS_W-1:0]   op_b;
	logic [PROD_W-1:0]  prod_q;
	logic [ABS_W-1:0]   conv_mg;
	logic [SUM_W-1:0]   sum_next;
	logic               strong_c;
	logic [2:0]         dom_onehot;
	logic [1:0]         seen_count;
	logic               sqrt_start;
	logic               sqrt_done;
	logic [ROOT_W-1:0]  sqrt_root;

	assign accept    = sample.valid && sample.ready;
	assign out_free  = !result.valid || result.ready;
	assign emit_fire = (state_q == S_FINISH) && emit_q && out_free;
	assign sample.ready = (state_q == S_IDLE);
	assign err_next  = err_q + 3'd1;

	always_comb begin
		case (cnt_q)
			2'd0:    raw_sel = raw_q[0];
			2'd1:    raw_sel = raw_q[1];
			2'd2:    raw_sel = raw_q[2];
			default: raw_sel = '0;
		endcase
	end

	assign raw_abs = raw_sel[RAW_W-1] ? ({1'b0, ~raw_sel} + ABS_W'(1)) : {1'b0, raw_sel};

	always_comb begin
		op_a = raw_abs;
		op_b = MG_PER_G;
		if (state_q == S_SQ) begin
			case (cnt_q)
				2'd0:    op_a = absmg_q[0];
				2'd1:    op_a = absmg_q[1];
				2'd2:    op_a = absmg_q[2];
				default: op_a = '0;
			endcase
			op_b = op_a;
		end
	end

	atpc_mul u_mul (
		.clk    (clk),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod_q (prod_q)
	);

	assign conv_mg    = prod_q[LSB_SHIFT +: ABS_W];
	assign sum_next   = sum_q + SUM_W'(prod_q);
	assign strong_c   = best_q >= thr_q;
	assign dom_onehot = 3'b001 << dom_q;
	assign seen_count = 2'(seen_q[0]) + 2'(seen_q[1]) + 2'(seen_q[2]);
	assign sqrt_start = (state_q == S_SQ) && (cnt_q == 2'd3);

	atpc_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sum_next),
		.done_q   (sqrt_done),
		.root     (sqrt_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= THRESHOLD_RESET;
			need_q    <= AXES_NEED_RESET;
			max_err_q <= MAX_ERRORS_RESET;
		end else if (wr_en) begin
			case (wr_index)
				CFG_THRESHOLD:  thr_q     <= wr_data[THR_W-1:0];
				CFG_AXES_NEED:  need_q    <= wr_data[1:0];
				CFG_MAX_ERRORS: max_err_q <= wr_data[2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			seen_q       <= '0;
			err_q        <= '0;
			emit_q       <= 1'b0;
			lost_q       <= 1'b0;
			result.valid <= 1'b0;
		end else begin
			if (emit_fire) begin
				result.valid <= 1'b1;
			end else if (result.valid && result.ready) begin
				result.valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						if (sample.read_ok) begin
							err_q   <= '0;
							emit_q  <= 1'b1;
							lost_q  <= 1'b0;
							state_q <= S_CONV;
						end else if (err_next >= max_err_q) begin
							err_q   <= '0;
							seen_q  <= '0;
							emit_q  <= 1'b1;
							lost_q  <= 1'b1;
							state_q <= S_FINISH;
						end else begin
							err_q   <= err_next;
							emit_q  <= 1'b0;
							lost_q  <= 1'b0;
							state_q <= S_FINISH;
						end
					end
				end
				S_CONV: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						if (strong_c) begin
							seen_q <= seen_q | dom_onehot;
						end
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sqrt_done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (!emit_q || out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			raw_q[0] <= sample.raw_x;
			raw_q[1] <= sample.raw_y;
			raw_q[2] <= sample.raw_z;
		end
		if (state_q == S_CONV) begin
			if (cnt_q == 2'd0) begin
				best_q <= '0;
				dom_q  <= 2'd0;
			end else begin
				absmg_q[cnt_q - 2'd1] <= conv_mg;
				if (conv_mg > best_q) begin
					best_q <= conv_mg;
					dom_q  <= cnt_q - 2'd1;
				end
			end
		end
		if (state_q == S_SQ) begin
			if (cnt_q == 2'd0) begin
				sum_q <= '0;
			end else begin
				sum_q <= sum_next;
			end
			if (cnt_q == 2'd3) begin
				strong_q <= strong_c;
			end
		end
		if (emit_fire) begin
			if (lost_q) begin
				result.phase           <= PHASE_LOST;
				result.magnitude_mg    <= '0;
				result.dominant_axis   <= '0;
				result.dominant_strong <= 1'b0;
				result.axes_seen_mask  <= '0;
				result.axes_seen_count <= '0;
			end else begin
				result.phase           <= (seen_count >= need_q) ? PHASE_PASSED : PHASE_RUNNING;
				result.magnitude_mg    <= sqrt_root;
				result.dominant_axis   <= dom_q;
				result.dominant_strong <= strong_q;
				result.axes_seen_mask  <= seen_q;
				result.axes_seen_count <= seen_count;
			end
		end
	end

endmodule
